@@ hdl/bfloat16_log10_unit_defines.svh @@
// Assertion macros shared by the log10 unit
`ifndef BFLOAT16_LOG10_UNIT_DEFINES_SVH
`define BFLOAT16_LOG10_UNIT_DEFINES_SVH

// ante holds -> cons holds on the same edge
`define BL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// ante holds -> cons holds after the delay given by n
`define BL_ASSERT_DLY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/bf16l10_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bf16l10_pkg;

    localparam int FRAC_BITS   = 53;
    localparam int QUO_BITS    = 56;
    localparam int FRAC_STAGES = QUO_BITS / 2;

    localparam logic [15:0] NEG_INF = 16'hFF80;
    localparam logic [15:0] POS_INF = 16'h7F80;
    localparam logic [15:0] QNAN    = 16'hFFFF;
    localparam logic [15:0] ONE     = 16'h3F80;

    localparam logic [63:0] COEF_C0 = 64'd6044690829402082;
    localparam logic [63:0] COEF_C1 = 64'd8615249784491564;
    localparam logic [63:0] COEF_C2 = 64'd25989907958083224;
    localparam logic [54:0] LOG2_TEN = 55'd29921268260572612;

    typedef logic [127:0][55:0] ytab_t;

    function automatic logic [63:0] mul_q53(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[116:53];
    endfunction

    // t = (k << 53) / (256 + k), shift-subtract, elaboration only
    function automatic logic [63:0] t_of(input logic [6:0] k);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] r;
        logic [63:0] q;
        num = {57'b0, k} << FRAC_BITS;
        den = 64'd256 + {57'b0, k};
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            if (r >= den)
            begin
                r = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // odd polynomial of t for every 7-bit significand
    function automatic ytab_t build_ytab();
        ytab_t tab;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] y;
        for (int k = 0; k < 128; k++)
        begin
            t  = t_of(7'(k));
            t2 = mul_q53(t, t);
            y  = mul_q53(COEF_C0, t2) + COEF_C1;
            y  = mul_q53(y, t2) + COEF_C2;
            y  = mul_q53(y, t);
            tab[k] = y[55:0];
        end
        return tab;
    endfunction

    localparam ytab_t YTAB = build_ytab();

endpackage
`default_nettype wire

@@ hdl/bfloat16_log10_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   | ports                        | transaction
// ----------+------------------------------+--------------------------------
// operand   | start, busy, operand_bits    | edge with start high, busy low
// result    | done, result_bits            | edge ending the done cycle
//
// One operand per cycle; busy stays low. From the accepting edge to the edge
// that takes the result an operand passes decode, magnitude, 3 integer-quotient
// stages and 28 fraction stages of two quotient bits each, leading-one, pack.
// Reset clears the valid bits of all stages; in-flight work is dropped.
// The receiver cannot stall, so the pipeline never holds.
`include "bfloat16_log10_unit_defines.svh"
module bfloat16_log10_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] operand_bits,
    output logic             busy,
    output logic             done,
    output logic [15:0]      result_bits
);

    localparam int FS = bf16l10_pkg::FRAC_STAGES;
    localparam int IS = 3;
    localparam int LATENCY = FS + 8;

    assign busy = 1'b0;

    // ---------------- decode ----------------
    logic        dec_v_reg;
    logic        dec_byp_reg, dec_byp_next;
    logic [15:0] dec_bval_reg, dec_bval_next;
    logic [6:0]  dec_k_reg, dec_k_next;
    logic [8:0]  dec_e_reg, dec_e_next;

    always_comb
    begin
        logic [7:0] expf;
        logic [6:0] frac;
        logic [2:0] b;
        expf = operand_bits[14:7];
        frac = operand_bits[6:0];
        b = 3'd0;
        for (int i = 1; i < 7; i++)
        begin
            if (frac[i])
            begin
                b = 3'(i);
            end
        end
        dec_byp_next  = 1'b1;
        dec_bval_next = bf16l10_pkg::QNAN;
        if (operand_bits == 16'h0000 || operand_bits == 16'h8000)
        begin
            dec_bval_next = bf16l10_pkg::NEG_INF;
        end
        else if (operand_bits == bf16l10_pkg::POS_INF)
        begin
            dec_bval_next = bf16l10_pkg::POS_INF;
        end
        else if (operand_bits > bf16l10_pkg::POS_INF)
        begin
            dec_bval_next = bf16l10_pkg::QNAN;
        end
        else if (operand_bits == bf16l10_pkg::ONE)
        begin
            dec_bval_next = 16'h0000;
        end
        else
        begin
            dec_byp_next = 1'b0;
        end
        if (expf == 8'd0)
        begin
            dec_k_next = 7'(frac << (3'd7 - b));
            dec_e_next = 9'({6'b0, b}) - 9'd133;
        end
        else
        begin
            dec_k_next = frac;
            dec_e_next = {1'b0, expf} - 9'd127;
        end
    end

    // ---------------- magnitude of e + y ----------------
    logic        mag_neg_next;
    logic [61:0] mag_next;

    always_comb
    begin
        logic [55:0] y;
        logic [7:0]  e_abs;
        logic [61:0] e_sh;
        y = bf16l10_pkg::YTAB[dec_k_reg];
        mag_neg_next = dec_e_reg[8];
        e_abs = mag_neg_next ? 8'(-dec_e_reg) : dec_e_reg[7:0];
        e_sh = {54'b0, e_abs} << bf16l10_pkg::FRAC_BITS;
        mag_next = mag_neg_next ? e_sh - {6'b0, y} : e_sh + {6'b0, y};
    end

    // ---------------- integer quotient ----------------
    logic        iv_reg   [0:IS];
    logic        ibyp_reg [0:IS];
    logic [15:0] ibval_reg[0:IS];
    logic        ineg_reg [0:IS];
    logic [61:0] ir_reg   [0:IS];
    logic [5:0]  iq_reg   [0:IS];

    logic        fv_reg   [0:FS];
    logic        fbyp_reg [0:FS];
    logic [15:0] fbval_reg[0:FS];
    logic        fneg_reg [0:FS];
    logic [54:0] fr_reg   [0:FS];
    logic [61:0] fq_reg   [0:FS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_v_reg <= 1'b0;
            iv_reg[0] <= 1'b0;
            fv_reg[0] <= 1'b0;
        end
        else
        begin
            dec_v_reg <= start;
            iv_reg[0] <= dec_v_reg;
            fv_reg[0] <= iv_reg[IS];
        end
    end

    always_ff @(posedge clk)
    begin
        dec_byp_reg  <= dec_byp_next;
        dec_bval_reg <= dec_bval_next;
        dec_k_reg    <= dec_k_next;
        dec_e_reg    <= dec_e_next;
        ibyp_reg[0]  <= dec_byp_reg;
        ibval_reg[0] <= dec_bval_reg;
        ineg_reg[0]  <= mag_neg_next;
        ir_reg[0]    <= mag_next;
        iq_reg[0]    <= '0;
        fbyp_reg[0]  <= ibyp_reg[IS];
        fbval_reg[0] <= ibval_reg[IS];
        fneg_reg[0]  <= ineg_reg[IS];
        fr_reg[0]    <= ir_reg[IS][54:0];
        fq_reg[0]    <= {56'b0, iq_reg[IS]};
    end

    // integer part of the quotient is below 64: two bits per stage, MSB first
    for (genvar h = 0; h < IS; h++)
    begin : g_int
        localparam logic [61:0] D_HI = {7'b0, bf16l10_pkg::LOG2_TEN} << (5 - 2 * h);
        localparam logic [61:0] D_LO = {7'b0, bf16l10_pkg::LOG2_TEN} << (4 - 2 * h);
        logic [61:0] r_mid, r_out;
        logic        b_hi, b_lo;

        always_comb
        begin
            b_hi  = ir_reg[h] >= D_HI;
            r_mid = b_hi ? ir_reg[h] - D_HI : ir_reg[h];
            b_lo  = r_mid >= D_LO;
            r_out = b_lo ? r_mid - D_LO : r_mid;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                iv_reg[h+1] <= 1'b0;
            end
            else
            begin
                iv_reg[h+1] <= iv_reg[h];
            end
        end

        always_ff @(posedge clk)
        begin
            ibyp_reg[h+1]  <= ibyp_reg[h];
            ibval_reg[h+1] <= ibval_reg[h];
            ineg_reg[h+1]  <= ineg_reg[h];
            ir_reg[h+1]    <= r_out;
            iq_reg[h+1]    <= {iq_reg[h][3:0], b_hi, b_lo};
        end
    end

    // ---------------- fraction quotient, two bits per stage ----------------
    for (genvar g = 0; g < FS; g++)
    begin : g_frac
        logic [55:0] r_sh0, r_sh1;
        logic [54:0] r_mid, r_out;
        logic        b0, b1;

        always_comb
        begin
            r_sh0 = {fr_reg[g], 1'b0};
            b0    = r_sh0 >= {1'b0, bf16l10_pkg::LOG2_TEN};
            r_mid = b0 ? 55'(r_sh0 - {1'b0, bf16l10_pkg::LOG2_TEN}) : r_sh0[54:0];
            r_sh1 = {r_mid, 1'b0};
            b1    = r_sh1 >= {1'b0, bf16l10_pkg::LOG2_TEN};
            r_out = b1 ? 55'(r_sh1 - {1'b0, bf16l10_pkg::LOG2_TEN}) : r_sh1[54:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fv_reg[g+1] <= 1'b0;
            end
            else
            begin
                fv_reg[g+1] <= fv_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            fbyp_reg[g+1]  <= fbyp_reg[g];
            fbval_reg[g+1] <= fbval_reg[g];
            fneg_reg[g+1]  <= fneg_reg[g];
            fr_reg[g+1]    <= r_out;
            fq_reg[g+1]    <= {fq_reg[g][59:0], b0, b1};
        end
    end

    // ---------------- leading-one count ----------------
    logic        lz_v_reg;
    logic        lz_byp_reg;
    logic [15:0] lz_bval_reg;
    logic        lz_neg_reg;
    logic        lz_sticky_reg;
    logic [61:0] lz_q_reg;
    logic [5:0]  lz_reg, lz_next;

    always_comb
    begin
        logic found;
        found = 1'b0;
        lz_next = '0;
        for (int i = 61; i >= 0; i--)
        begin
            if (!found && fq_reg[FS][i])
            begin
                lz_next = 6'(61 - i);
                found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lz_v_reg <= 1'b0;
        end
        else
        begin
            lz_v_reg <= fv_reg[FS];
        end
    end

    always_ff @(posedge clk)
    begin
        lz_byp_reg    <= fbyp_reg[FS];
        lz_bval_reg   <= fbval_reg[FS];
        lz_neg_reg    <= fneg_reg[FS];
        lz_sticky_reg <= fr_reg[FS] != '0;
        lz_q_reg      <= fq_reg[FS];
        lz_reg        <= lz_next;
    end

    // ---------------- normalize, round to nearest even, pack ----------------
    logic        done_reg;
    logic [15:0] result_bits_reg, result_bits_next;

    always_comb
    begin
        logic [61:0] qn;
        logic        guard;
        logic        rest;
        logic [8:0]  mant;
        logic [8:0]  bexp;
        qn    = lz_q_reg << lz_reg;
        guard = qn[53];
        rest  = (qn[52:0] != '0) || lz_sticky_reg;
        mant  = {1'b0, qn[61:54]} + 9'(guard && (rest || qn[54]));
        bexp  = 9'd132 - {3'b0, lz_reg};
        if (mant[8])
        begin
            mant = 9'h080;
            bexp = bexp + 9'd1;
        end
        if (lz_byp_reg)
        begin
            result_bits_next = lz_bval_reg;
        end
        else
        begin
            result_bits_next = {lz_neg_reg, bexp[7:0], mant[6:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lz_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_bits_reg <= result_bits_next;
    end

    assign done        = done_reg;
    assign result_bits = result_bits_reg;

    `BL_ASSERT_DLY(a_latency, start, LATENCY, done)
    `BL_ASSERT_DLY(a_one_gives_zero, start && operand_bits == bf16l10_pkg::ONE, LATENCY, result_bits == 16'h0000)
    `BL_ASSERT_DLY(a_neg_gives_nan, start && operand_bits > 16'h8000, LATENCY, result_bits == bf16l10_pkg::QNAN)
    `BL_ASSERT_IMPL(a_done_follows_pipe, done, $past(lz_v_reg))

endmodule
`default_nettype wire
